### design/tnvp_pkg.sv
// Shared constants for the tag name/value/unit parser.
`default_nettype none
package tnvp_pkg;

   // Payload widths fixed by the character format
   localparam int CHAR_BITS = 21;
   localparam int DEST_BITS = 2;
   localparam int FRAC_BITS = 4;

   // Defaults for the top-level parameters
   localparam int MANTISSA_BITS_DEFAULT = 48;
   localparam int TRIM_BITS_DEFAULT     = 12;

   // Character codes
   localparam logic [CHAR_BITS-1:0] CH_EQUAL  = 21'h00003D;
   localparam logic [CHAR_BITS-1:0] CH_BSLASH = 21'h00005C;
   localparam logic [CHAR_BITS-1:0] CH_SPACE  = 21'h000020;
   localparam logic [CHAR_BITS-1:0] CH_TAB    = 21'h000009;
   localparam logic [CHAR_BITS-1:0] CH_COMMA  = 21'h00002C;
   localparam logic [CHAR_BITS-1:0] CH_DOT    = 21'h00002E;
   localparam logic [CHAR_BITS-1:0] CH_MINUS  = 21'h00002D;
   localparam logic [CHAR_BITS-1:0] CH_ZERO   = 21'h000030;
   localparam logic [CHAR_BITS-1:0] CH_NINE   = 21'h000039;

   // Fraction digit count ceiling
   localparam logic [FRAC_BITS-1:0] FRAC_MAX = 4'd15;

   // Character destination codes
   localparam logic [DEST_BITS-1:0] DEST_DROP = 2'd0;
   localparam logic [DEST_BITS-1:0] DEST_NAME = 2'd1;
   localparam logic [DEST_BITS-1:0] DEST_UNIT = 2'd2;

endpackage
`default_nettype wire

### design/tnvp_req_if.sv
// Character channel: valid/ready handshake carrying one text character.
`default_nettype none
interface tnvp_req_if;
   import tnvp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] char_code;
   logic                 last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

### design/tnvp_rsp_if.sv
// Result channel: valid/ready handshake carrying destination and summary fields.
`default_nettype none
interface tnvp_rsp_if #(
   parameter int MANTISSA_BITS = tnvp_pkg::MANTISSA_BITS_DEFAULT,
   parameter int TRIM_BITS     = tnvp_pkg::TRIM_BITS_DEFAULT
);
   import tnvp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [DEST_BITS-1:0]     char_dest;
   logic [CHAR_BITS-1:0]     char_echo;
   logic                     done_res;
   logic                     name_found;
   logic                     value_found;
   logic                     unit_found;
   logic [MANTISSA_BITS-1:0] value_magnitude;
   logic                     value_negative;
   logic [FRAC_BITS-1:0]     fraction_digits;
   logic [TRIM_BITS-1:0]     name_trim;
   logic [TRIM_BITS-1:0]     unit_trim;
   logic                     overflow;

   modport source (
      output valid, input ready,
      output char_dest, output char_echo, output done_res,
      output name_found, output value_found, output unit_found,
      output value_magnitude, output value_negative, output fraction_digits,
      output name_trim, output unit_trim, output overflow
   );
   modport sink (
      input valid, output ready,
      input char_dest, input char_echo, input done_res,
      input name_found, input value_found, input unit_found,
      input value_magnitude, input value_negative, input fraction_digits,
      input name_trim, input unit_trim, input overflow
   );
endinterface
`default_nettype wire

### design/tnvp_core.sv
// Parser state, per-character update and result register.
`default_nettype none
module tnvp_core #(
   parameter int MANTISSA_BITS = tnvp_pkg::MANTISSA_BITS_DEFAULT,
   parameter int TRIM_BITS     = tnvp_pkg::TRIM_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic [tnvp_pkg::CHAR_BITS-1:0] in_char,
   input  wire logic                           in_last,
   output      logic                           in_take,
   input  wire logic                           out_ready,
   output      logic                           out_valid,
   output      logic [tnvp_pkg::DEST_BITS-1:0] out_dest,
   output      logic [tnvp_pkg::CHAR_BITS-1:0] out_echo,
   output      logic                           out_done,
   output      logic                           out_name_found,
   output      logic                           out_value_found,
   output      logic                           out_unit_found,
   output      logic [MANTISSA_BITS-1:0]       out_magnitude,
   output      logic                           out_negative,
   output      logic [tnvp_pkg::FRAC_BITS-1:0] out_frac,
   output      logic [TRIM_BITS-1:0]           out_name_trim,
   output      logic [TRIM_BITS-1:0]           out_unit_trim,
   output      logic                           out_overflow
);
   import tnvp_pkg::*;

   localparam int PROD_BITS = MANTISSA_BITS + 4;

   typedef enum logic [1:0] {
      MODE_NAME,
      MODE_ESC,
      MODE_VALUE,
      MODE_UNIT
   } mode_type;

   // Parser state
   mode_type                 mode_ff, mode_in;
   logic                     name_started_ff, name_started_in;
   logic                     decimal_seen_ff, decimal_seen_in;
   logic                     minus_seen_ff, minus_seen_in;
   logic                     digit_seen_ff, digit_seen_in;
   logic [MANTISSA_BITS-1:0] mantissa_ff, mantissa_in;
   logic [FRAC_BITS-1:0]     fraction_count_ff, fraction_count_in;
   logic [TRIM_BITS-1:0]     name_trailing_ff, name_trailing_in;
   logic [TRIM_BITS-1:0]     unit_trailing_ff, unit_trailing_in;
   logic                     saturated_ff, saturated_in;

   // Result register
   logic                     out_valid_ff;
   logic [DEST_BITS-1:0]     dest_ff, dest_in;
   logic [CHAR_BITS-1:0]     echo_ff;
   logic                     done_ff, done_in;
   logic                     name_found_ff, name_found_in;
   logic                     value_found_ff, value_found_in;
   logic                     unit_found_ff, unit_found_in;
   logic [MANTISSA_BITS-1:0] magnitude_ff, magnitude_in;
   logic                     negative_ff, negative_in;
   logic [FRAC_BITS-1:0]     frac_ff, frac_in;
   logic [TRIM_BITS-1:0]     name_trim_ff, name_trim_in;
   logic [TRIM_BITS-1:0]     unit_trim_ff, unit_trim_in;
   logic                     overflow_ff, overflow_in;

   // Character classes
   logic                     is_bslash, is_equal, is_blank, is_mark, is_minus, is_digit;
   logic                     in_num;
   logic [PROD_BITS-1:0]     mant_ext, mant_prod;

   // Take an item whenever the result register is empty or being drained
   assign in_take = in_valid && (!out_valid_ff || out_ready);

   assign is_bslash = (in_char == CH_BSLASH);
   assign is_equal  = (in_char == CH_EQUAL);
   assign is_blank  = (in_char == CH_SPACE) || (in_char == CH_TAB);
   assign is_mark   = (in_char == CH_COMMA) || (in_char == CH_DOT);
   assign is_minus  = (in_char == CH_MINUS);
   assign is_digit  = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
   assign in_num    = (mode_ff == MODE_VALUE) || (mode_ff == MODE_UNIT);

   // Multiply by ten and add the digit; upper bits set means saturation
   assign mant_ext  = {4'b0000, mantissa_ff};
   assign mant_prod = (mant_ext << 3) + (mant_ext << 1)
                      + {{(PROD_BITS-4){1'b0}}, in_char[3:0]};

   // Per-character mode update and destination
   always_comb begin
      logic go_name;
      logic go_unit;
      logic boolean_tag;

      go_name           = 1'b0;
      go_unit           = 1'b0;
      boolean_tag       = 1'b0;
      mode_in           = mode_ff;
      name_started_in   = name_started_ff;
      decimal_seen_in   = decimal_seen_ff;
      minus_seen_in     = minus_seen_ff;
      digit_seen_in     = digit_seen_ff;
      mantissa_in       = mantissa_ff;
      fraction_count_in = fraction_count_ff;
      name_trailing_in  = name_trailing_ff;
      unit_trailing_in  = unit_trailing_ff;
      saturated_in      = saturated_ff;
      dest_in           = DEST_DROP;

      if (is_bslash) begin
         if (in_num) begin
            go_unit = 1'b1;
         end else if (mode_ff == MODE_ESC) begin
            go_name = 1'b1;
         end else begin
            mode_in = MODE_ESC;
         end
      end else if (is_equal) begin
         if (!name_started_ff || mode_ff == MODE_ESC) begin
            go_name = 1'b1;
         end else if (in_num) begin
            go_unit = 1'b1;
         end else begin
            mode_in = MODE_VALUE;
         end
      end else if (is_blank) begin
         if (mode_ff == MODE_NAME || mode_ff == MODE_ESC) begin
            if (name_started_ff) begin
               dest_in = DEST_NAME;
               if (&name_trailing_ff) begin
                  saturated_in = 1'b1;
               end else begin
                  name_trailing_in = name_trailing_ff + 1'b1;
               end
            end
         end else if (mode_ff == MODE_UNIT) begin
            dest_in = DEST_UNIT;
            if (&unit_trailing_ff) begin
               saturated_in = 1'b1;
            end else begin
               unit_trailing_in = unit_trailing_ff + 1'b1;
            end
         end
      end else if (is_mark) begin
         if (decimal_seen_ff || mode_ff == MODE_UNIT) begin
            go_unit = 1'b1;
         end else if (mode_ff == MODE_VALUE) begin
            decimal_seen_in = 1'b1;
         end else begin
            go_name = 1'b1;
         end
      end else if (is_minus) begin
         if (minus_seen_ff || mode_ff == MODE_UNIT) begin
            go_unit = 1'b1;
         end else if (mode_ff == MODE_VALUE) begin
            minus_seen_in = 1'b1;
         end else begin
            go_name = 1'b1;
         end
      end else if (is_digit) begin
         if (mode_ff == MODE_VALUE) begin
            digit_seen_in = 1'b1;
            if (mant_prod[PROD_BITS-1:MANTISSA_BITS] != 4'b0000) begin
               mantissa_in  = '1;
               saturated_in = 1'b1;
            end else begin
               mantissa_in = mant_prod[MANTISSA_BITS-1:0];
            end
            if (decimal_seen_ff) begin
               if (fraction_count_ff >= FRAC_MAX) begin
                  saturated_in = 1'b1;
               end else begin
                  fraction_count_in = fraction_count_ff + 1'b1;
               end
            end
         end else if (mode_ff == MODE_UNIT) begin
            unit_trailing_in = '0;
            dest_in          = DEST_UNIT;
         end else begin
            go_name = 1'b1;
         end
      end else if (in_num) begin
         go_unit = 1'b1;
      end else begin
         go_name = 1'b1;
      end

      // Enter name or unit mode
      if (go_name) begin
         name_started_in  = 1'b1;
         name_trailing_in = '0;
         mode_in          = MODE_NAME;
         dest_in          = DEST_NAME;
      end
      if (go_unit) begin
         unit_trailing_in = '0;
         mode_in          = MODE_UNIT;
         dest_in          = DEST_UNIT;
      end

      // Summary on the last character, zero otherwise
      done_in        = in_last;
      name_found_in  = 1'b0;
      value_found_in = 1'b0;
      unit_found_in  = 1'b0;
      magnitude_in   = '0;
      negative_in    = 1'b0;
      frac_in        = '0;
      name_trim_in   = '0;
      unit_trim_in   = '0;
      overflow_in    = 1'b0;
      if (in_last) begin
         boolean_tag    = (mode_in == MODE_NAME) && name_started_in;
         unit_found_in  = (mode_in == MODE_UNIT);
         name_found_in  = (mode_in == MODE_UNIT) || name_started_in;
         value_found_in = digit_seen_in;
         if (boolean_tag) begin
            magnitude_in = {{(MANTISSA_BITS-1){1'b0}}, 1'b1};
         end else begin
            magnitude_in = mantissa_in;
            negative_in  = minus_seen_in;
            frac_in      = fraction_count_in;
         end
         name_trim_in = name_trailing_in;
         unit_trim_in = unit_trailing_in;
         overflow_in  = saturated_in;

         // Clear the state for the next text
         mode_in           = MODE_NAME;
         name_started_in   = 1'b0;
         decimal_seen_in   = 1'b0;
         minus_seen_in     = 1'b0;
         digit_seen_in     = 1'b0;
         mantissa_in       = '0;
         fraction_count_in = '0;
         name_trailing_in  = '0;
         unit_trailing_in  = '0;
         saturated_in      = 1'b0;
      end
   end

   // Hold state and result register; advance on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_NAME;
         name_started_ff   <= 1'b0;
         decimal_seen_ff   <= 1'b0;
         minus_seen_ff     <= 1'b0;
         digit_seen_ff     <= 1'b0;
         mantissa_ff       <= '0;
         fraction_count_ff <= '0;
         name_trailing_ff  <= '0;
         unit_trailing_ff  <= '0;
         saturated_ff      <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else if (in_take) begin
         mode_ff           <= mode_in;
         name_started_ff   <= name_started_in;
         decimal_seen_ff   <= decimal_seen_in;
         minus_seen_ff     <= minus_seen_in;
         digit_seen_ff     <= digit_seen_in;
         mantissa_ff       <= mantissa_in;
         fraction_count_ff <= fraction_count_in;
         name_trailing_ff  <= name_trailing_in;
         unit_trailing_ff  <= unit_trailing_in;
         saturated_ff      <= saturated_in;
         out_valid_ff      <= 1'b1;
         dest_ff           <= dest_in;
         echo_ff           <= in_char;
         done_ff           <= done_in;
         name_found_ff     <= name_found_in;
         value_found_ff    <= value_found_in;
         unit_found_ff     <= unit_found_in;
         magnitude_ff      <= magnitude_in;
         negative_ff       <= negative_in;
         frac_ff           <= frac_in;
         name_trim_ff      <= name_trim_in;
         unit_trim_ff      <= unit_trim_in;
         overflow_ff       <= overflow_in;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign out_valid       = out_valid_ff;
   assign out_dest        = dest_ff;
   assign out_echo        = echo_ff;
   assign out_done        = done_ff;
   assign out_name_found  = name_found_ff;
   assign out_value_found = value_found_ff;
   assign out_unit_found  = unit_found_ff;
   assign out_magnitude   = magnitude_ff;
   assign out_negative    = negative_ff;
   assign out_frac        = frac_ff;
   assign out_name_trim   = name_trim_ff;
   assign out_unit_trim   = unit_trim_ff;
   assign out_overflow    = overflow_ff;

endmodule
`default_nettype wire

### design/tag_name_value_unit_parser_top.sv
// Tag name/value/unit parser top level: input register, parser core, assertions.
// Splits a tag text such as "name = -3.5 kg", one character per transfer, into
// name, signed decimal value and unit. Every character yields one result giving
// its destination (dropped, name or unit); the character flagged last also
// carries the summary (presence flags, mantissa with fraction digit count, trailing
// blank counts, overflow) and clears the parser for the next text. Throughput is
// one character per cycle while neither side stalls, set by the per-character
// update of the parser state (mode and multiply-by-ten accumulate); a character goes
// via the input register and result register; both sides may stall freely.
`default_nettype none
module tag_name_value_unit_parser_top #(
   parameter int MANTISSA_BITS = tnvp_pkg::MANTISSA_BITS_DEFAULT,
   parameter int TRIM_BITS     = tnvp_pkg::TRIM_BITS_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   tnvp_req_if.sink   req_if,
   tnvp_rsp_if.source rsp_if
);
   import tnvp_pkg::*;

   // Input register
   logic                 s1_valid_ff;
   logic [CHAR_BITS-1:0] s1_char_ff;
   logic                 s1_last_ff;
   logic                 core_take;

   logic [MANTISSA_BITS-1:0] magnitude;
   logic [TRIM_BITS-1:0]     name_trim;
   logic [TRIM_BITS-1:0]     unit_trim;

   // Accept while the input register is empty or moving on
   assign req_if.ready = !s1_valid_ff || core_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
         s1_char_ff  <= req_if.char_code;
         s1_last_ff  <= req_if.last;
      end
   end

   tnvp_core #(
      .MANTISSA_BITS (MANTISSA_BITS),
      .TRIM_BITS     (TRIM_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s1_valid_ff),
      .in_char         (s1_char_ff),
      .in_last         (s1_last_ff),
      .in_take         (core_take),
      .out_ready       (rsp_if.ready),
      .out_valid       (rsp_if.valid),
      .out_dest        (rsp_if.char_dest),
      .out_echo        (rsp_if.char_echo),
      .out_done        (rsp_if.done_res),
      .out_name_found  (rsp_if.name_found),
      .out_value_found (rsp_if.value_found),
      .out_unit_found  (rsp_if.unit_found),
      .out_magnitude   (magnitude),
      .out_negative    (rsp_if.value_negative),
      .out_frac        (rsp_if.fraction_digits),
      .out_name_trim   (name_trim),
      .out_unit_trim   (unit_trim),
      .out_overflow    (rsp_if.overflow)
   );

   assign rsp_if.value_magnitude = magnitude;
   assign rsp_if.name_trim       = name_trim;
   assign rsp_if.unit_trim       = unit_trim;

   // A unit part always implies a name
   a_unit_has_name: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.unit_found |-> rsp_if.name_found)
      else $error("unit reported without a name");

   // Summary fields stay quiet on characters that are not last
   a_quiet_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.done_res |->
         magnitude == '0 && !rsp_if.name_found && !rsp_if.value_found &&
         !rsp_if.overflow && name_trim == '0 && unit_trim == '0)
      else $error("summary fields set on a non-final character");

   // Destination code is one of the three defined
   a_dest_code: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.char_dest == DEST_DROP ||
         rsp_if.char_dest == DEST_NAME || rsp_if.char_dest == DEST_UNIT)
      else $error("undefined destination code");

   // A held character in the input register is never lost
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !core_take |=> s1_valid_ff && $stable(s1_char_ff))
      else $error("pending character dropped from input register");

endmodule
`default_nettype wire

### bench/tnvp_text_checker.sv
// Scoreboard for the tag text parser: predicts each result and compares it on the result channel.
module tnvp_text_checker #(
   parameter int MANTISSA_BITS = tnvp_pkg::MANTISSA_BITS_DEFAULT,
   parameter int TRIM_BITS     = tnvp_pkg::TRIM_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   tnvp_req_if  req_mon,
   tnvp_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending
);
   import tnvp_pkg::*;

   localparam logic [63:0] MANT_MAX  = (64'd1 << MANTISSA_BITS) - 64'd1;
   localparam int          PRINT_CAP = 40;

   typedef enum logic [1:0] {
      MODE_NAME,
      MODE_ESC,
      MODE_VALUE,
      MODE_UNIT
   } parse_mode_type;

   typedef struct packed {
      logic [DEST_BITS-1:0]     dest;
      logic [CHAR_BITS-1:0]     echo;
      logic                     done;
      logic                     name_found;
      logic                     value_found;
      logic                     unit_found;
      logic [MANTISSA_BITS-1:0] magnitude;
      logic                     negative;
      logic [FRAC_BITS-1:0]     frac;
      logic [TRIM_BITS-1:0]     name_trim;
      logic [TRIM_BITS-1:0]     unit_trim;
      logic                     ovf;
   } char_result_type;

   // Parser state as the block should hold it
   parse_mode_type       st_mode;
   logic                 st_named;
   logic                 st_decimal;
   logic                 st_minus;
   logic                 st_digit;
   logic [63:0]          st_mant;
   logic [FRAC_BITS-1:0] st_frac;
   logic [TRIM_BITS-1:0] st_name_blank;
   logic [TRIM_BITS-1:0] st_unit_blank;
   logic                 st_sat;

   char_result_type expected_results[$];

   function automatic void clear_parse();
      st_mode       = MODE_NAME;
      st_named      = 1'b0;
      st_decimal    = 1'b0;
      st_minus      = 1'b0;
      st_digit      = 1'b0;
      st_mant       = '0;
      st_frac       = '0;
      st_name_blank = '0;
      st_unit_blank = '0;
      st_sat        = 1'b0;
   endfunction

   function automatic logic [TRIM_BITS-1:0] count_blank(logic [TRIM_BITS-1:0] t);
      if (t == '1) begin
         st_sat = 1'b1;
         return t;
      end
      return t + 1'b1;
   endfunction

   function automatic logic [DEST_BITS-1:0] enter_name();
      st_named      = 1'b1;
      st_name_blank = '0;
      st_mode       = MODE_NAME;
      return DEST_NAME;
   endfunction

   function automatic logic [DEST_BITS-1:0] enter_unit();
      st_unit_blank = '0;
      st_mode       = MODE_UNIT;
      return DEST_UNIT;
   endfunction

   // Steer one character and update the parser state
   function automatic logic [DEST_BITS-1:0] route_char(logic [CHAR_BITS-1:0] c);
      logic        in_num;
      logic [63:0] d;
      in_num = (st_mode == MODE_VALUE) || (st_mode == MODE_UNIT);
      if (c == CH_BSLASH) begin
         if (in_num) return enter_unit();
         if (st_mode == MODE_ESC) return enter_name();
         st_mode = MODE_ESC;
         return DEST_DROP;
      end
      if (c == CH_EQUAL) begin
         if (!st_named || st_mode == MODE_ESC) return enter_name();
         if (in_num) return enter_unit();
         st_mode = MODE_VALUE;
         return DEST_DROP;
      end
      if (c == CH_SPACE || c == CH_TAB) begin
         if (st_mode == MODE_NAME || st_mode == MODE_ESC) begin
            if (!st_named) return DEST_DROP;
            st_name_blank = count_blank(st_name_blank);
            return DEST_NAME;
         end
         if (st_mode == MODE_UNIT) begin
            st_unit_blank = count_blank(st_unit_blank);
            return DEST_UNIT;
         end
         return DEST_DROP;
      end
      if (c == CH_COMMA || c == CH_DOT) begin
         if (st_decimal || st_mode == MODE_UNIT) return enter_unit();
         if (st_mode == MODE_VALUE) begin
            st_decimal = 1'b1;
            return DEST_DROP;
         end
         return enter_name();
      end
      if (c == CH_MINUS) begin
         if (st_minus || st_mode == MODE_UNIT) return enter_unit();
         if (st_mode == MODE_VALUE) begin
            st_minus = 1'b1;
            return DEST_DROP;
         end
         return enter_name();
      end
      if (c >= CH_ZERO && c <= CH_NINE) begin
         if (st_mode == MODE_VALUE) begin
            d        = 64'(c - CH_ZERO);
            st_digit = 1'b1;
            // accumulate, holding at the ceiling
            if (st_mant > (MANT_MAX - d) / 64'd10) begin
               st_mant = MANT_MAX;
               st_sat  = 1'b1;
            end else begin
               st_mant = st_mant * 64'd10 + d;
            end
            if (st_decimal) begin
               if (st_frac >= FRAC_MAX) st_sat = 1'b1;
               else st_frac = st_frac + 1'b1;
            end
            return DEST_DROP;
         end
         if (st_mode == MODE_UNIT) begin
            st_unit_blank = '0;
            return DEST_UNIT;
         end
         return enter_name();
      end
      if (in_num) return enter_unit();
      return enter_name();
   endfunction

   // Work out the full result of one character, summary included on the last one
   function automatic char_result_type predict_char(logic [CHAR_BITS-1:0] c, logic is_last);
      char_result_type r;
      logic            unit_end;
      logic            bool_tag;
      r      = '0;
      r.dest = route_char(c);
      r.echo = c;
      if (is_last) begin
         unit_end      = (st_mode == MODE_UNIT);
         bool_tag      = (st_mode == MODE_NAME) && st_named;
         r.done        = 1'b1;
         r.name_found  = unit_end || st_named;
         r.value_found = st_digit;
         r.unit_found  = unit_end;
         if (bool_tag) begin
            r.magnitude = MANTISSA_BITS'(1);
         end else begin
            r.magnitude = st_mant[MANTISSA_BITS-1:0];
            r.negative  = st_minus;
            r.frac      = st_frac;
         end
         r.name_trim = st_name_blank;
         r.unit_trim = st_unit_blank;
         r.ovf       = st_sat;
         clear_parse();
      end
      return r;
   endfunction

   task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= PRINT_CAP)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   // Compare results first, then record the new expectation
   always @(posedge clock) begin : monitor
      char_result_type want;
      if (reset) begin
         clear_parse();
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= PRINT_CAP)
                  $display("%0t: result with none expected, expected nothing, actual echo %0h",
                           $time, rsp_mon.char_echo);
            end else begin
               want = expected_results.pop_front();
               check_field("char_dest", 64'(want.dest), 64'(rsp_mon.char_dest));
               check_field("char_echo", 64'(want.echo), 64'(rsp_mon.char_echo));
               check_field("done_res", 64'(want.done), 64'(rsp_mon.done_res));
               check_field("name_found", 64'(want.name_found), 64'(rsp_mon.name_found));
               check_field("value_found", 64'(want.value_found), 64'(rsp_mon.value_found));
               check_field("unit_found", 64'(want.unit_found), 64'(rsp_mon.unit_found));
               check_field("value_magnitude", 64'(want.magnitude),
                           64'(rsp_mon.value_magnitude));
               check_field("value_negative", 64'(want.negative), 64'(rsp_mon.value_negative));
               check_field("fraction_digits", 64'(want.frac), 64'(rsp_mon.fraction_digits));
               check_field("name_trim", 64'(want.name_trim), 64'(rsp_mon.name_trim));
               check_field("unit_trim", 64'(want.unit_trim), 64'(rsp_mon.unit_trim));
               check_field("overflow", 64'(want.ovf), 64'(rsp_mon.overflow));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.insert(expected_results.size(),
                                    predict_char(req_mon.char_code, req_mon.last));
      end
      pending = expected_results.size();
   end

endmodule

### bench/tag_name_value_unit_parser_top_tb.sv
// Testbench top for the tag text parser: clock, reset, character stimulus and verdict.
module tag_name_value_unit_parser_top_tb;
   import tnvp_pkg::*;

   localparam int MANT_W       = MANTISSA_BITS_DEFAULT;
   localparam int TRIM_W       = TRIM_BITS_DEFAULT;
   localparam int RANDOM_ITEMS = 1550;
   localparam int QUIET_FROM   = 1350;
   localparam int LONG_RUN     = 40;
   localparam int CYCLE_LIMIT  = 600000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycle_count;
   bit   quiet;
   bit   calm;

   logic [CHAR_BITS-1:0] text_q[$];

   tnvp_req_if req_if ();
   tnvp_rsp_if #(.MANTISSA_BITS(MANT_W), .TRIM_BITS(TRIM_W)) rsp_if ();

   tag_name_value_unit_parser_top #(
      .MANTISSA_BITS(MANT_W),
      .TRIM_BITS    (TRIM_W)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   tnvp_text_checker #(
      .MANTISSA_BITS(MANT_W),
      .TRIM_BITS    (TRIM_W)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_if),
      .rsp_mon   (rsp_if),
      .fail_count(fail_count),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop if the run hangs
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Result side: stall in bursts, with calm stretches and none at the end
   initial begin : result_side
      int stall_left;
      int stretch_left;
      stall_left    = 0;
      stretch_left  = 0;
      calm          = 1'b0;
      rsp_if.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stretch_left == 0) begin
            calm         = ($urandom_range(0, 2) == 0);
            stretch_left = $urandom_range(50, 300);
         end
         stretch_left--;
         if (stall_left > 0) stall_left--;
         else if (!quiet && !calm && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
         rsp_if.ready <= (stall_left == 0);
      end
   end

   function automatic logic [CHAR_BITS-1:0] blank_char();
      return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_char();
      return CH_ZERO + CHAR_BITS'($urandom_range(0, 9));
   endfunction

   // Mostly lower-case letters, now and then a code point far outside ASCII
   function automatic logic [CHAR_BITS-1:0] letter_char();
      if ($urandom_range(0, 7) == 0) return CHAR_BITS'($urandom_range(21'h80, 21'h1FFFFF));
      return CHAR_BITS'($urandom_range(8'h61, 8'h7A));
   endfunction

   function automatic logic [CHAR_BITS-1:0] any_char();
      logic [CHAR_BITS-1:0] specials[7];
      specials = '{CH_EQUAL, CH_BSLASH, CH_SPACE, CH_TAB, CH_COMMA, CH_DOT, CH_MINUS};
      case ($urandom_range(0, 3))
         0: return specials[$urandom_range(0, 6)];
         1: return digit_char();
         2: return CHAR_BITS'($urandom_range(0, 21'h1FFFFF));
         default: return letter_char();
      endcase
   endfunction

   // Append one character to the text being built
   task automatic queue_char(logic [CHAR_BITS-1:0] c);
      text_q.insert(text_q.size(), c);
   endtask

   task automatic push_str(string s);
      for (int i = 0; i < s.len(); i++) queue_char(CHAR_BITS'(s[i]));
   endtask

   task automatic push_many(logic [CHAR_BITS-1:0] c, int n);
      repeat (n) queue_char(c);
   endtask

   // Present one character from a falling edge and hold it until the transfer
   task automatic send_char(logic [CHAR_BITS-1:0] c, logic is_last);
      if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.char_code <= c;
      req_if.last      <= is_last;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // Send the queued text, flag its final character, and clear the queue
   task automatic send_text(inout int sent);
      int count;
      count = text_q.size();
      for (int i = 0; i < count; i++) send_char(text_q[i], i == count - 1);
      sent += count;
      text_q.delete();
   endtask

   // Hold off until every expected result has come back
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   // Mostly well-formed "name = -12.5 unit" texts, some noise and some broken ones
   task automatic build_random_text();
      int n;
      text_q.delete();
      if ($urandom_range(0, 99) < 15) begin
         n = $urandom_range(1, 12);
         repeat (n) queue_char(any_char());
         return;
      end
      if ($urandom_range(0, 3) == 0) queue_char(blank_char());
      n = $urandom_range(1, 6);
      repeat (n) begin
         case ($urandom_range(0, 9))
            0: begin
               queue_char(CH_BSLASH);
               queue_char($urandom_range(0, 1) ? CH_EQUAL : letter_char());
            end
            1: queue_char(blank_char());
            2: queue_char(any_char());
            default: queue_char(letter_char());
         endcase
      end
      repeat ($urandom_range(0, 3)) queue_char(blank_char());
      case ($urandom_range(0, 9))
         0, 1: ;
         2: queue_char(CH_BSLASH);
         default: begin
            queue_char(CH_EQUAL);
            repeat ($urandom_range(0, 2)) queue_char(blank_char());
            if ($urandom_range(0, 2) == 0) queue_char(CH_MINUS);
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 6);
            repeat (n) queue_char(digit_char());
            if ($urandom_range(0, 1)) begin
               queue_char($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
               n = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 4);
               repeat (n) queue_char(digit_char());
            end
            repeat ($urandom_range(0, 2)) queue_char(blank_char());
            if ($urandom_range(0, 1)) begin
               n = $urandom_range(1, 4);
               repeat (n) begin
                  case ($urandom_range(0, 5))
                     0: queue_char(digit_char());
                     1: queue_char(blank_char());
                     2: queue_char(any_char());
                     default: queue_char(letter_char());
                  endcase
               end
               repeat ($urandom_range(0, 3)) queue_char(blank_char());
            end
         end
      endcase
      // break the odd sequence
      if ($urandom_range(0, 9) == 0) text_q[$urandom_range(0, text_q.size() - 1)] = any_char();
   endtask

   initial begin : stimulus
      int sent;
      int texts;
      sent             = 0;
      texts            = 0;
      quiet            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.char_code = '0;
      req_if.last      = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: boolean tag, escape at the end, code extremes, full value, escapes, two marks
      push_str("a");
      send_text(sent);
      push_str("\\");
      send_text(sent);
      queue_char(21'h1FFFFF);
      queue_char(21'h000000);
      send_text(sent);
      push_str(" x=-3.5 k\t");
      send_text(sent);
      push_str("=\\=");
      send_text(sent);
      push_str("n=1,2.3");
      send_text(sent);
      drain();

      // Saturation corners: mantissa at and past its ceiling, fraction count; long blank runs
      push_str("m=281474976710655");
      send_text(sent);
      push_str("m=281474976710656");
      send_text(sent);
      push_str("v=");
      push_many(CH_NINE, 20);
      send_text(sent);
      push_str("f=.");
      push_many(CH_ZERO, 17);
      send_text(sent);
      push_str("t");
      push_many(CH_SPACE, LONG_RUN);
      send_text(sent);
      push_str("t=1u");
      push_many(CH_TAB, LONG_RUN);
      send_text(sent);
      drain();

      // Random texts; the tail runs without any idling
      while (sent < RANDOM_ITEMS) begin
         quiet = (sent >= QUIET_FROM);
         build_random_text();
         send_text(sent);
         texts++;
         if (texts % 20 == 0 && !quiet) drain();
      end
      req_if.valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
